// ----- hw/rtl/rkc_pkg.sv -----
`default_nettype none
package rkc_pkg;

    localparam int MaxWidth   = 1024;
    localparam int MaxKernel  = 5;
    localparam int MaxHeight  = 4096;
    localparam int PackedTaps = 5;
    localparam int Channels   = 3;
    localparam int LineSpan   = (MaxKernel - 1) * MaxWidth + MaxKernel;
    localparam int LineAw     = $clog2(LineSpan);
    localparam int LineDepth  = 1 << LineAw;
    localparam int PosW       = 23;
    localparam int ColW       = 11;
    localparam int RowW       = 13;
    localparam int AccW       = 25;
    localparam int SumW       = 18;
    localparam int QuoW       = 24;
    localparam int PaddrW     = 6;

    localparam logic [2:0] RegWidth  = 3'd0;
    localparam logic [2:0] RegHeight = 3'd1;
    localparam logic [2:0] RegKsize  = 3'd2;
    localparam logic [2:0] RegCoef0  = 3'd3;

    typedef struct packed {
        logic       is_padding;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
        logic       zero_divisor;
    } pix_out_t;

    // one tap request, held for its own cell of the chain
    typedef struct packed {
        logic                    vld;
        logic                    inb;
        logic signed [11:0]      coef;
        logic [7:0]              pr;
        logic [7:0]              pg;
        logic [7:0]              pb;
    } tap_t;

    typedef struct packed {
        logic                    vld;
        logic signed [AccW-1:0]  ar;
        logic signed [AccW-1:0]  ag;
        logic signed [AccW-1:0]  ab;
        logic signed [SumW-1:0]  cs;
    } part_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } ctl_state_t;

    function automatic logic [7:0] sat8(input logic signed [QuoW:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rgb_kernel_convolution_top.sv -----
`default_nettype none
// channel | dir | words
// s_      | in  | pixel or flush word, rkc_pkg::pix_in_t
// m_      | out | filtered pixel, rkc_pkg::pix_out_t
// apb     | in  | config registers at 8*i
// One word at a time. A word with no result leaves the block idle; one with
// a result goes through a window read from line RAM (one tap a cycle), the
// 25-cell chain and the divider (one bit a cycle) before it is offered on
// m_; a zero kernel sum skips the divider.
// Reset is synchronous; the line RAM is not cleared. m_ stalls hold the
// result and keep s_ready low.
module rgb_kernel_convolution_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire rkc_pkg::pix_in_t          s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output rkc_pkg::pix_out_t              m_data,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rkc_pkg::PaddrW-1:0] paddr,
    input  wire logic [63:0]               pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);
    import rkc_pkg::*;

    localparam int NT = MaxKernel * MaxKernel;
    localparam int TW = $clog2(NT + 1);

    logic [10:0] wreg_reg;
    logic [12:0] hreg_reg;
    logic [2:0]  kreg_reg;
    logic [59:0] coef_reg [PackedTaps];
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx = paddr[PaddrW-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wreg_reg <= 11'd640;
            hreg_reg <= 13'd480;
            kreg_reg <= 3'd3;
            for (int i = 0; i < PackedTaps; i++) begin
                coef_reg[i] <= (i == 1) ? 60'd65536 : 60'd0;
            end
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                RegWidth:  wreg_reg <= pwdata[10:0];
                RegHeight: hreg_reg <= pwdata[12:0];
                RegKsize:  kreg_reg <= pwdata[2:0];
                default: begin
                    for (int i = 0; i < PackedTaps; i++) begin
                        if (ridx == RegCoef0 + 3'(i)) begin
                            coef_reg[i] <= pwdata[59:0];
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (ridx)
            RegWidth:  prdata = {53'd0, wreg_reg};
            RegHeight: prdata = {51'd0, hreg_reg};
            RegKsize:  prdata = {61'd0, kreg_reg};
            default: begin
                for (int i = 0; i < PackedTaps; i++) begin
                    if (ridx == RegCoef0 + 3'(i)) begin
                        prdata = {4'd0, coef_reg[i]};
                    end
                end
            end
        endcase
    end

    // clamped configuration
    logic [ColW-1:0] w;
    logic [RowW-1:0] h;
    logic [2:0]      k;
    logic [1:0]      half;
    logic [PosW:0]   frame;
    logic [PosW-1:0] lag;

    always_comb begin
        w = (wreg_reg == 0) ? ColW'(1) : (wreg_reg > MaxWidth) ? ColW'(MaxWidth) : wreg_reg;
        h = (hreg_reg == 0) ? RowW'(1) : (hreg_reg > MaxHeight) ? RowW'(MaxHeight) : hreg_reg;
        k = (kreg_reg == 0) ? 3'd1 : (kreg_reg > MaxKernel) ? 3'(MaxKernel) : kreg_reg;
        half = k[2:1];
        frame = (PosW+1)'(w * h);
        lag = PosW'(half * w) + PosW'(half);
    end

    ctl_state_t state_reg, state_next;
    logic [ColW-1:0] icol_reg, ocol_reg;
    logic [RowW-1:0] irow_reg, orow_reg;
    logic [PosW-1:0] p, q;
    logic [4:0]      tr_reg, tc_reg;
    logic [TW-1:0]   cnt_reg;
    pix_out_t        out_reg;
    logic            fend_reg;

    assign p = PosW'(irow_reg * w) + PosW'(icol_reg);
    assign q = PosW'(orow_reg * w) + PosW'(ocol_reg);

    // tap address generation
    logic signed [RowW+1:0] ty;
    logic signed [ColW+1:0] tx;
    logic            tin;
    logic [PosW-1:0] taddr;
    logic [LineAw-1:0] raddr;
    logic [23:0]     rdata;
    logic signed [11:0] tcoef;
    logic [59:0]     crow;

    always_comb begin
        ty = $signed({2'b0, orow_reg}) + $signed({10'd0, tr_reg}) - $signed({13'd0, half});
        tx = $signed({2'b0, ocol_reg}) + $signed({8'd0, tc_reg}) - $signed({11'd0, half});
        tin = !(ty < 0 || tx < 0 || ty >= $signed({2'b0, h}) || tx >= $signed({2'b0, w}));
        taddr = PosW'(ty[RowW-1:0] * w) + PosW'(tx[ColW-1:0]);
        raddr = taddr[LineAw-1:0];
        crow = coef_reg[tr_reg[2:0]];
        tcoef = $signed(crow[tc_reg[2:0]*12 +: 12]);
    end

    logic ram_we;
    assign ram_we = (state_reg == ST_IDLE) && s_valid && (p < frame) && !s_data.is_padding;

    rkc_ram #(.Width(24), .Depth(LineDepth)) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (p[LineAw-1:0]),
        .wdata ({s_data.blue_in, s_data.green_in, s_data.red_in}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // tap request stage aligned to RAM latency; tap i feeds cell i
    logic  tvld_reg, tinb_reg;
    logic signed [11:0] tcoef_reg;
    logic [TW-1:0] tidx_reg;
    tap_t  taps [NT];
    part_t parts [NT+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvld_reg <= 1'b0;
        end else begin
            tvld_reg <= (state_reg == ST_GATHER) && (tr_reg < 5'(k));
        end
        tinb_reg  <= tin;
        tcoef_reg <= tcoef;
        tidx_reg  <= TW'(tr_reg * 5 + tc_reg);
    end

    // taps are latched into per-cell holding registers
    tap_t hold_reg [NT];
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NT; i++) begin
            if (state_reg == ST_IDLE) begin
                hold_reg[i].vld <= 1'b0;
            end else if (tvld_reg && tidx_reg == TW'(i)) begin
                hold_reg[i] <= '{vld: 1'b1, inb: tinb_reg, coef: tcoef_reg,
                                 pr: rdata[7:0], pg: rdata[15:8], pb: rdata[23:16]};
            end
        end
    end

    // sums enter during ACC, once the last tap has landed in its holding register
    assign parts[0] = '{vld: (state_reg == ST_ACC) && (cnt_reg == TW'(1)), ar: '0, ag: '0,
                        ab: '0, cs: '0};

    for (genvar g = 0; g < NT; g++) begin : g_cell
        assign taps[g] = hold_reg[g];
        rkc_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .part_i (parts[g]),
            .tap_i  (taps[g]),
            .part_o (parts[g+1])
        );
    end

    logic dv_done;
    logic [7:0] qr, qg, qb;
    logic zero_div;
    logic div_start;
    assign zero_div = (parts[NT].cs == 0);
    assign div_start = parts[NT].vld && !zero_div;

    rkc_div u_div (
        .aclk (aclk), .aresetn(aresetn), .start(div_start),
        .nr(parts[NT].ar), .ng(parts[NT].ag), .nb(parts[NT].ab), .den(parts[NT].cs),
        .done(dv_done), .qr(qr), .qg(qg), .qb(qb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            icol_reg <= '0; irow_reg <= '0; ocol_reg <= '0; orow_reg <= '0;
            tr_reg <= '0; tc_reg <= '0; cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && !(p < frame && s_data.is_padding)) begin
                        if (icol_reg + 1'b1 >= w) begin
                            icol_reg <= '0;
                            irow_reg <= irow_reg + 1'b1;
                        end else begin
                            icol_reg <= icol_reg + 1'b1;
                        end
                        tr_reg <= '0; tc_reg <= '0;
                    end
                end
                ST_GATHER: begin
                    if (tc_reg + 1'b1 >= 5'(k)) begin
                        tc_reg <= '0;
                        tr_reg <= tr_reg + 1'b1;
                    end else begin
                        tc_reg <= tc_reg + 1'b1;
                    end
                    cnt_reg <= '0;
                end
                ST_ACC: begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DIV: begin
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (fend_reg) begin
                            icol_reg <= '0; irow_reg <= '0;
                            ocol_reg <= '0; orow_reg <= '0;
                        end else if (ocol_reg + 1'b1 >= w) begin
                            ocol_reg <= '0;
                            orow_reg <= orow_reg + 1'b1;
                        end else begin
                            ocol_reg <= ocol_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_GATHER) begin
            fend_reg <= (PosW+1)'(q) + 1'b1 >= frame;
        end
        if (parts[NT].vld && zero_div) begin
            out_reg <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                         frame_end: fend_reg, zero_divisor: 1'b1};
        end else if (dv_done) begin
            out_reg <= '{red_out: qr, green_out: qg, blue_out: qb,
                         frame_end: fend_reg, zero_divisor: 1'b0};
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !(p < frame && s_data.is_padding) && p >= lag) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                if (tr_reg + 1'b1 >= 5'(k) && tc_reg + 1'b1 >= 5'(k)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (parts[NT].vld) begin
                    state_next = zero_div ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (dv_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/rkc_ram.sv -----
`default_nettype none
module rkc_ram #(
    parameter int Width = 24,
    parameter int Depth = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rkc_cell.sv -----
`default_nettype none
// One multiply-accumulate cell: takes its own tap and the running partial
// sums from its left neighbour, adds its product and hands the sums on.
module rkc_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rkc_pkg::part_t part_i,
    input  wire rkc_pkg::tap_t  tap_i,
    output rkc_pkg::part_t     part_o
);
    import rkc_pkg::*;

    part_t part_reg, part_next;
    logic signed [20:0] mr, mg, mb;

    always_comb begin
        mr = tap_i.coef * $signed({1'b0, tap_i.pr});
        mg = tap_i.coef * $signed({1'b0, tap_i.pg});
        mb = tap_i.coef * $signed({1'b0, tap_i.pb});
        part_next = part_i;
        if (tap_i.vld) begin
            part_next.cs = part_i.cs + SumW'(tap_i.coef);
            if (tap_i.inb) begin
                part_next.ar = part_i.ar + AccW'(mr);
                part_next.ag = part_i.ag + AccW'(mg);
                part_next.ab = part_i.ab + AccW'(mb);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg.vld <= 1'b0;
        end else begin
            part_reg.vld <= part_next.vld;
        end
        part_reg.ar <= part_next.ar;
        part_reg.ag <= part_next.ag;
        part_reg.ab <= part_next.ab;
        part_reg.cs <= part_next.cs;
    end

    assign part_o = part_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/rkc_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit a cycle, three channels in parallel.
module rkc_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [rkc_pkg::AccW-1:0] nr,
    input  wire logic signed [rkc_pkg::AccW-1:0] ng,
    input  wire logic signed [rkc_pkg::AccW-1:0] nb,
    input  wire logic signed [rkc_pkg::SumW-1:0] den,
    output logic                          done,
    output logic [7:0]                    qr,
    output logic [7:0]                    qg,
    output logic [7:0]                    qb
);
    import rkc_pkg::*;

    localparam int CntW = $clog2(QuoW + 1);

    logic [QuoW-1:0] num_reg [Channels];
    logic [QuoW-1:0] rem_reg [Channels];
    logic            neg_reg [Channels];
    logic [SumW-1:0] dmag_reg;
    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic signed [AccW-1:0] nin [Channels];
    logic [QuoW:0]   trial [Channels];
    logic [SumW-1:0] dmag;
    logic signed [QuoW:0] sq [Channels];

    assign nin[0] = nr;
    assign nin[1] = ng;
    assign nin[2] = nb;
    assign dmag = den[SumW-1] ? SumW'(-den) : SumW'(den);

    always_comb begin
        for (int i = 0; i < Channels; i++) begin
            trial[i] = {rem_reg[i], num_reg[i][QuoW-1]} - (QuoW+1)'(dmag_reg);
            sq[i] = neg_reg[i] ? -$signed({1'b0, num_reg[i]}) : $signed({1'b0, num_reg[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dmag_reg <= dmag;
                for (int i = 0; i < Channels; i++) begin
                    num_reg[i] <= nin[i][AccW-1] ? QuoW'(-nin[i]) : QuoW'(nin[i]);
                    rem_reg[i] <= '0;
                    neg_reg[i] <= nin[i][AccW-1] ^ den[SumW-1];
                end
            end else if (busy_reg) begin
                for (int i = 0; i < Channels; i++) begin
                    if (!trial[i][QuoW]) begin
                        rem_reg[i] <= trial[i][QuoW-1:0];
                        num_reg[i] <= {num_reg[i][QuoW-2:0], 1'b1};
                    end else begin
                        rem_reg[i] <= {rem_reg[i][QuoW-2:0], num_reg[i][QuoW-1]};
                        num_reg[i] <= {num_reg[i][QuoW-2:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(QuoW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign qr = sat8(sq[0]);
    assign qg = sat8(sq[1]);
    assign qb = sat8(sq[2]);
endmodule
`default_nettype wire

// ----- hw/rtl/rkc_checker.sv -----
`default_nettype none
module rkc_checker (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire rkc_pkg::pix_out_t m_data
);
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_divisor |-> m_data.red_out == 8'd0)
        else $error("zero divisor not black");
    a_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready) else $error("no return to idle");
endmodule

bind rgb_kernel_convolution_top rkc_checker u_chk (.*);
`default_nettype wire

// ----- dv/rgb_kernel_convolution_top_tb.sv -----
module rgb_kernel_convolution_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rkc_pkg::*;

    localparam int StoreDepth = (MaxKernel - 1) * MaxWidth + MaxKernel;
    localparam int IdlePct    = 29;
    localparam int StallLimit = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pix_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pix_out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    always #5 aclk = ~aclk;

    rgb_kernel_convolution_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter state
    logic [23:0] pix_ring [StoreDepth];
    int unsigned in_col, in_row, out_col, out_row;
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [2:0]  cfg_ksize;
    logic [59:0] cfg_coef [5];

    pix_out_t pixels_due[$];
    int fails, checked, words_sent, frames_seen, zero_div_seen;
    bit no_idle, hold_off;
    int quiet_cycles;
    pix_out_t first_due;
    bit first_seen;

    task automatic report(input string what, input pix_out_t got, input pix_out_t want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fails++;
    endtask

    function automatic int unsigned clampu(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        return v > hi ? hi : v;
    endfunction

    function automatic int signed coef_of(int r, int c);
        logic signed [11:0] raw;
        raw = cfg_coef[r][12*c +: 12];
        return raw;
    endfunction

    // returns 1 and fills res when a filtered pixel falls due
    function automatic bit filter_word(input pix_in_t w, output pix_out_t res);
        int unsigned wd, ht, k, half, frame, lag, p, q;
        longint acc [3];
        longint csum, quo;
        int y, x, cf;
        logic [23:0] pix;
        bit fend;
        wd = clampu(cfg_width, MaxWidth);
        ht = clampu(cfg_height, MaxHeight);
        k = clampu(cfg_ksize, MaxKernel);
        half = k / 2;
        frame = wd * ht;
        lag = half * wd + half;
        p = in_row * wd + in_col;
        res = '0;
        if (p < frame) begin
            if (w.is_padding) return 0;
            pix_ring[p % StoreDepth] = {w.blue_in, w.green_in, w.red_in};
        end
        in_col++;
        if (in_col >= wd) begin
            in_col = 0;
            in_row++;
        end
        if (p < lag) return 0;
        acc = '{0, 0, 0};
        csum = 0;
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < k; c++) begin
                cf = coef_of(r, c);
                y = int'(out_row) + r - int'(half);
                x = int'(out_col) + c - int'(half);
                csum += cf;
                if (y < 0 || x < 0 || y >= int'(ht) || x >= int'(wd)) continue;
                pix = pix_ring[(y * wd + x) % StoreDepth];
                for (int ch = 0; ch < 3; ch++) acc[ch] += longint'(cf) * pix[8*ch +: 8];
            end
        end
        q = out_row * wd + out_col;
        fend = (q + 1) >= frame;
        for (int ch = 0; ch < 3; ch++) begin
            quo = csum == 0 ? 0 : acc[ch] / csum;
            if (quo < 0) quo = 0;
            if (quo > 255) quo = 255;
            if (ch == 0) res.red_out = quo[7:0];
            if (ch == 1) res.green_out = quo[7:0];
            if (ch == 2) res.blue_out = quo[7:0];
        end
        res.frame_end = fend;
        res.zero_divisor = csum == 0;
        if (fend) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else begin
            out_col++;
            if (out_col >= wd) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PaddrW'(idx) << 3; pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegWidth:  cfg_width = v[10:0];
            RegHeight: cfg_height = v[12:0];
            RegKsize:  cfg_ksize = v[2:0];
            default:   cfg_coef[idx - RegCoef0] = v[59:0];
        endcase
    endtask

    // valid is left high after the accept; the next word or an idle cycle
    // takes it over at the following falling edge
    task automatic send_word(input pix_in_t w);
        pix_out_t res;
        while (!no_idle && $urandom_range(99) < IdlePct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (filter_word(w, res)) begin
            pixels_due = {pixels_due, res};
            if (!first_seen) begin
                first_due = res;
                first_seen = 1'b1;
            end
        end
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_idle;
        while (pixels_due.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    function automatic pix_in_t rand_pixel();
        pix_in_t w;
        w.is_padding = 1'b0;
        w.red_in = 8'($urandom);
        w.green_in = 8'($urandom);
        w.blue_in = 8'($urandom);
        return w;
    endfunction

    function automatic logic [59:0] rand_kernel(input bit tame);
        logic [59:0] v;
        v = 60'({$urandom, $urandom});
        if (tame) for (int c = 0; c < 5; c++) v[12*c +: 12] = 12'($urandom_range(0, 40));
        return v;
    endfunction

    // run a whole frame, then flush with words, mostly padding, until its last pixel falls due
    task automatic run_frame(input int wd, input int ht, input bit flat);
        pix_in_t w;
        for (int i = 0; i < wd * ht; i++) begin
            w = rand_pixel();
            if (flat) w = {1'b0, 24'hffffff};
            if ($urandom_range(19) == 0) w.is_padding = 1'b1;
            send_word(w);
            if (w.is_padding) i--;
        end
        while (in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0) begin
            w = rand_pixel();
            w.is_padding = $urandom_range(3) != 0;
            send_word(w);
        end
        s_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                report("unexpected word", m_data, '0);
            end else begin
                if (m_data.red_out != pixels_due[0].red_out)
                    report("red", m_data, pixels_due[0]);
                if (m_data.green_out != pixels_due[0].green_out)
                    report("green", m_data, pixels_due[0]);
                if (m_data.blue_out != pixels_due[0].blue_out)
                    report("blue", m_data, pixels_due[0]);
                if (m_data.frame_end != pixels_due[0].frame_end)
                    report("frame_end", m_data, pixels_due[0]);
                if (m_data.zero_divisor != pixels_due[0].zero_divisor)
                    report("zero_divisor", m_data, pixels_due[0]);
                frames_seen += m_data.frame_end;
                zero_div_seen += m_data.zero_divisor;
                void'(pixels_due.pop_front());
                checked++;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= no_idle || $urandom_range(99) >= IdlePct;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    typedef struct {
        logic [10:0] wd;
        logic [12:0] ht;
        logic [2:0]  ks;
        logic [59:0] row0, row1, row2;
        bit flat;
        bit typed;
        logic [7:0] want;
    } frame_row_t;

    frame_row_t directed [] = '{
        '{11'd1, 13'd1, 3'd1, 60'h0, 60'h0, 60'h0, 1'b1, 1'b1, 8'd0},
        '{11'd1, 13'd1, 3'd1, 60'h10, 60'h0, 60'h0, 1'b1, 1'b1, 8'd255},
        '{11'd4, 13'd3, 3'd3, 60'h010010010, 60'h010010010, 60'h010010010,
          1'b1, 1'b1, 8'd113},
        '{11'd4, 13'd3, 3'd3, 60'h0, 60'h0, 60'h0, 1'b0, 1'b1, 8'd0},
        '{11'd5, 13'd4, 3'd5, 60'h7ff800010fff001, 60'h800001, 60'h7ff,
          1'b0, 1'b0, 8'd0},
        '{11'd0, 13'd0, 3'd0, 60'h10, 60'h0, 60'h0, 1'b0, 1'b0, 8'd0},
        '{11'd3, 13'd2, 3'd7, 60'hfffffffffffffff, 60'h1, 60'h0, 1'b0, 1'b0, 8'd0},
        '{11'd2, 13'd5, 3'd2, 60'hff0010, 60'h020fff, 60'h0, 1'b0, 1'b0, 8'd0}
    };

    initial begin
        int wd, ht;
        pix_out_t typed_want;
        cfg_width = 11'd640; cfg_height = 13'd480; cfg_ksize = 3'd3;
        cfg_coef = '{60'd0, 60'd65536, 60'd0, 60'd0, 60'd0};
        for (int i = 0; i < StoreDepth; i++) pix_ring[i] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(negedge aclk);

        foreach (directed[i]) begin
            apb_write(RegWidth, directed[i].wd);
            apb_write(RegHeight, directed[i].ht);
            apb_write(RegKsize, directed[i].ks);
            apb_write(RegCoef0, directed[i].row0);
            apb_write(RegCoef0 + 3'd1, directed[i].row1);
            apb_write(RegCoef0 + 3'd2, directed[i].row2);
            apb_write(RegCoef0 + 3'd3, i == 4 ? 60'h00000000fff : 60'h0);
            apb_write(RegCoef0 + 3'd4, i == 4 ? 60'h800000000000000 : 60'h0);
            first_seen = 1'b0;
            run_frame(clampu(directed[i].wd, MaxWidth), clampu(directed[i].ht, MaxHeight),
                      directed[i].flat);
            if (directed[i].typed && first_seen && first_due.red_out != directed[i].want) begin
                typed_want = first_due;
                typed_want.red_out = directed[i].want;
                report("directed table", first_due, typed_want);
            end
            drain_idle();
        end

        // long receiver hold-off so the block backs up
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            run_frame(6, 3, 1'b0);
        join
        drain_idle();

        while (words_sent < 220) begin
            wd = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
            ht = $urandom_range(1, 6);
            apb_write(RegWidth, wd);
            apb_write(RegHeight, ht);
            apb_write(RegKsize, $urandom_range(7));
            for (int r = 0; r < 5; r++)
                apb_write(RegCoef0 + 3'(r), rand_kernel($urandom_range(2) != 0));
            run_frame(wd, ht, 1'b0);
            drain_idle();
        end
        // back to the widest frame for a single row, with no idling at all
        no_idle = 1'b1;
        apb_write(RegWidth, 11'd1024);
        apb_write(RegHeight, 13'd1);
        apb_write(RegKsize, 3'd1);
        apb_write(RegCoef0, 60'h10);
        run_frame(1024, 1, 1'b0);
        drain_idle();
        no_idle = 1'b0;

        $display("%0d words sent, %0d filtered pixels checked", words_sent, checked);
        $display("%0d frames completed, %0d zero-sum kernels", frames_seen, zero_div_seen);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/rkc_pkg.sv
hw/rtl/rkc_ram.sv
hw/rtl/rkc_cell.sv
hw/rtl/rkc_div.sv
hw/rtl/rgb_kernel_convolution_top.sv
hw/rtl/rkc_checker.sv
dv/rgb_kernel_convolution_top_tb.sv
